/* rtl/core/rpap_pkg.sv */
// rpap_pkg: shared widths and the request type of the shared multiplier
// for the roll/pitch attitude PID. Has no dependencies.

package rpap_pkg;

  localparam int CMD_W      = 10;
  localparam int RATE_W     = 14;
  localparam int ANG_W      = 12;
  localparam int GAIN_W     = 8;
  localparam int DRIVE_W    = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  // shared multiplier: signed operand times a gain or blend factor
  localparam int MUL_A_W = 16;
  localparam int MUL_B_W = 11;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  typedef struct packed {
    logic                      en;
    logic signed [MUL_A_W-1:0] a;
    logic signed [MUL_B_W-1:0] b;
  } mul_req_t;

endpackage

/* rtl/core/rpap_if.sv */
// rpap_if: valid/ready channels of the attitude PID, input items and results.
// Depends on rpap_pkg for field widths.

interface rpap_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [rpap_pkg::CMD_W-1:0]   roll_command;
  logic signed [rpap_pkg::CMD_W-1:0]   pitch_command;
  logic signed [rpap_pkg::RATE_W-1:0]  roll_rate;
  logic signed [rpap_pkg::RATE_W-1:0]  pitch_rate;
  logic signed [rpap_pkg::ANG_W-1:0]   roll_angle;
  logic signed [rpap_pkg::ANG_W-1:0]   pitch_angle;
  logic        [rpap_pkg::GAIN_W-1:0]  roll_rate_damp_gain;
  logic        [rpap_pkg::GAIN_W-1:0]  pitch_rate_damp_gain;
  logic                                reset_integrators;

  modport source (
    output valid, roll_command, pitch_command, roll_rate, pitch_rate,
           roll_angle, pitch_angle, roll_rate_damp_gain, pitch_rate_damp_gain,
           reset_integrators,
    input  ready
  );

  modport sink (
    input  valid, roll_command, pitch_command, roll_rate, pitch_rate,
           roll_angle, pitch_angle, roll_rate_damp_gain, pitch_rate_damp_gain,
           reset_integrators,
    output ready
  );
endinterface

interface rpap_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [rpap_pkg::DRIVE_W-1:0] roll_drive;
  logic signed [rpap_pkg::DRIVE_W-1:0] pitch_drive;

  modport source (output valid, roll_drive, pitch_drive, input ready);
  modport sink   (input valid, roll_drive, pitch_drive, output ready);
endinterface

/* rtl/core/rpap_mul.sv */
// rpap_mul: shared signed multiplier with registered product.
// Depends on rpap_pkg (mul_req_t, widths).

module rpap_mul (
  input  logic                                  clk,
  input  rpap_pkg::mul_req_t                    req,
  output logic signed [rpap_pkg::MUL_P_W-1:0]   prod
);

  logic signed [rpap_pkg::MUL_P_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (req.en) begin
      prod_r <= req.a * req.b;
    end
  end

  assign prod = prod_r;

endmodule

/* rtl/core/roll_pitch_attitude_pid.sv */
// roll_pitch_attitude_pid: rate / level / horizon PID for roll and pitch axes.
// Steps: nine per axis, roll then pitch; the input is ready again only when
// the pitch result has gone to the output register. The one shared multiplier
//   forms seven products per axis, roll then pitch, one product a cycle.
// Reset: synchronous, active low; clears integrators, gyro history and
//   handshake state, and loads the default gains and horizon mode.

module roll_pitch_attitude_pid (
  input  logic                             clk,
  input  logic                             rst_n,
  rpap_in_if.sink                          in_if,
  rpap_out_if.source                       out_if,
  input  logic                             cfg_we,
  input  logic [rpap_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rpap_pkg::CFG_DATA_W-1:0]  cfg_data
);

  // register map
  localparam logic [rpap_pkg::CFG_IDX_W-1:0] REG_ROLL_P  = 3'd0;
  localparam logic [rpap_pkg::CFG_IDX_W-1:0] REG_ROLL_I  = 3'd1;
  localparam logic [rpap_pkg::CFG_IDX_W-1:0] REG_PITCH_P = 3'd2;
  localparam logic [rpap_pkg::CFG_IDX_W-1:0] REG_PITCH_I = 3'd3;
  localparam logic [rpap_pkg::CFG_IDX_W-1:0] REG_LEVEL_P = 3'd4;
  localparam logic [rpap_pkg::CFG_IDX_W-1:0] REG_LEVEL_I = 3'd5;
  localparam logic [rpap_pkg::CFG_IDX_W-1:0] REG_MODE    = 3'd6;

  // level modes; the unused code behaves as acro
  localparam logic [1:0] MODE_ACRO    = 2'd0;
  localparam logic [1:0] MODE_ANGLE   = 2'd1;
  localparam logic [1:0] MODE_HORIZON = 2'd2;

  // limits
  localparam int RI_LIM    = 16000;
  localparam int LI_LIM    = 10000;
  localparam int RATE_LIM  = 640;
  localparam int PROP_MAX  = 512;
  localparam int CMD_LIM   = 500;
  localparam int DRIVE_MAX = 32767;
  localparam int DRIVE_MIN = -32768;

  // sequencer
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  // each step consumes the product issued by the step before, if any, and issues the next one, if any
  localparam logic [3:0] S_UPD    = 4'd0;  // integrator update, issue rc*P
  localparam logic [3:0] S_PRATE  = 4'd1;  // rate P, level integrator, issue I
  localparam logic [3:0] S_IRATE  = 4'd2;  // rate I, issue err*level P
  localparam logic [3:0] S_PACC   = 4'd3;  // level P, issue level I
  localparam logic [3:0] S_IACC   = 4'd4;  // level I, issue P blend
  localparam logic [3:0] S_PBLEND = 4'd5;  // P blend, issue I blend
  localparam logic [3:0] S_IBLEND = 4'd6;  // I blend, issue gyro damping
  localparam logic [3:0] S_DAMP   = 4'd7;  // damping, D sum, history shift
  localparam logic [3:0] S_DRIVE  = 4'd8;  // sum and saturate

  localparam int GW = rpap_pkg::GAIN_W;
  localparam int AW = rpap_pkg::MUL_A_W;
  localparam int BW = rpap_pkg::MUL_B_W;

  // ---------------------------------------------------------------- config
  logic [GW-1:0] rp_gain_r, ri_gain_r, pp_gain_r, pi_gain_r, lp_gain_r, li_gain_r;
  logic [1:0]    mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rp_gain_r <= 8'd40;
      ri_gain_r <= 8'd30;
      pp_gain_r <= 8'd40;
      pi_gain_r <= 8'd30;
      lp_gain_r <= 8'd90;
      li_gain_r <= 8'd10;
      mode_r    <= MODE_HORIZON;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROLL_P:  rp_gain_r <= cfg_data;
        REG_ROLL_I:  ri_gain_r <= cfg_data;
        REG_PITCH_P: pp_gain_r <= cfg_data;
        REG_PITCH_I: pi_gain_r <= cfg_data;
        REG_LEVEL_P: lp_gain_r <= cfg_data;
        REG_LEVEL_I: li_gain_r <= cfg_data;
        REG_MODE:    mode_r    <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  logic levelled;
  assign levelled = (mode_r == MODE_ANGLE) || (mode_r == MODE_HORIZON);

  // ---------------------------------------------------------------- control
  logic       state_r;
  logic [3:0] step_r;
  logic       axis_r;      // 0 roll, 1 pitch
  logic       out_valid_r;
  logic       in_xfer;
  logic       out_free;
  logic       finish;

  assign in_if.ready = (state_r == ST_IDLE);
  assign in_xfer     = in_if.valid && in_if.ready;
  assign out_free    = !out_valid_r || out_if.ready;
  // last step of pitch waits here until the output register is free
  assign finish      = (state_r == ST_RUN) && (step_r == S_DRIVE) && axis_r && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= S_UPD;
      axis_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        state_r <= ST_RUN;
        step_r  <= S_UPD;
        axis_r  <= 1'b0;
      end else if (state_r == ST_RUN) begin
        if (step_r != S_DRIVE) begin
          step_r <= step_r + 4'd1;
        end else if (!axis_r) begin
          step_r <= S_UPD;
          axis_r <= 1'b1;
        end else if (out_free) begin
          state_r <= ST_IDLE;
        end
      end
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- item latch
  logic signed [rpap_pkg::CMD_W-1:0]  rcmd_r, pcmd_r;
  logic signed [rpap_pkg::RATE_W-1:0] rrate_r, prate_r;
  logic signed [rpap_pkg::ANG_W-1:0]  rang_r, pang_r;
  logic [GW-1:0]                      rdamp_r, pdamp_r;
  logic [9:0]                         prop_r;   // horizon blend factor, 0..512

  logic [9:0] abs_roll, abs_pitch, abs_max, prop_nxt;

  always_comb begin
    // negating -512 in ten bits gives 512 read unsigned
    abs_roll  = in_if.roll_command[rpap_pkg::CMD_W-1] ?
                10'(-in_if.roll_command) : 10'(in_if.roll_command);
    abs_pitch = in_if.pitch_command[rpap_pkg::CMD_W-1] ?
                10'(-in_if.pitch_command) : 10'(in_if.pitch_command);
    abs_max   = (abs_roll > abs_pitch) ? abs_roll : abs_pitch;
    if (mode_r != MODE_HORIZON) begin
      prop_nxt = 10'd0;
    end else if (abs_max > 10'(PROP_MAX)) begin
      prop_nxt = 10'(PROP_MAX);
    end else begin
      prop_nxt = abs_max;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      rcmd_r  <= in_if.roll_command;
      pcmd_r  <= in_if.pitch_command;
      rrate_r <= in_if.roll_rate;
      prate_r <= in_if.pitch_rate;
      rang_r  <= in_if.roll_angle;
      pang_r  <= in_if.pitch_angle;
      rdamp_r <= in_if.roll_rate_damp_gain;
      pdamp_r <= in_if.pitch_rate_damp_gain;
      prop_r  <= prop_nxt;
    end
  end

  // per-axis view of the latched item and gains
  logic signed [rpap_pkg::CMD_W-1:0]  cmd_a;
  logic signed [rpap_pkg::RATE_W-1:0] rate_a;
  logic signed [rpap_pkg::ANG_W-1:0]  ang_a;
  logic [GW-1:0]                      damp_a, pg_a, ig_a;
  logic signed [10:0]                 rc_a;   // command doubled

  assign cmd_a  = axis_r ? pcmd_r  : rcmd_r;
  assign rate_a = axis_r ? prate_r : rrate_r;
  assign ang_a  = axis_r ? pang_r  : rang_r;
  assign damp_a = axis_r ? pdamp_r : rdamp_r;
  assign pg_a   = axis_r ? pp_gain_r : rp_gain_r;
  assign ig_a   = axis_r ? pi_gain_r : ri_gain_r;
  assign rc_a   = {cmd_a, 1'b0};

  // ---------------------------------------------------------------- axis state
  logic signed [14:0] ri_r   [2];   // rate integrator
  logic signed [14:0] li_r   [2];   // level integrator
  logic signed [13:0] prev_r [2];   // last gyro sample
  logic signed [14:0] dold_r [2];
  logic signed [14:0] dnew_r [2];

  // working registers of the current axis
  logic signed [12:0] err_r;
  logic signed [17:0] p_r;
  logic signed [11:0] i_r;
  logic signed [9:0]  pacc_r;
  logic signed [11:0] iacc_r;
  logic signed [16:0] d_r;
  logic signed [15:0] drv0_r;       // roll drive while pitch runs
  logic signed [15:0] roll_out_r, pitch_out_r;

  // shared multiplier
  rpap_pkg::mul_req_t                  mreq;
  logic signed [rpap_pkg::MUL_P_W-1:0] prod;

  rpap_mul u_mul (
    .clk  (clk),
    .req  (mreq),
    .prod (prod)
  );

  // combinational pieces of the update steps
  logic signed [16:0] ri_sum;
  logic signed [14:0] ri_nxt;
  logic               rate_big;
  logic signed [10:0] rc_cl;
  logic signed [12:0] err_nxt;
  logic signed [15:0] li_sum;
  logic signed [14:0] li_nxt;
  logic signed [19:0] pacc_sh;
  logic signed [9:0]  pacc_nxt;
  logic signed [14:0] delta;
  logic signed [19:0] drv_sum;
  logic signed [15:0] drv_sat;

  always_comb begin
    ri_sum   = 17'(ri_r[axis_r]) + 17'(rc_a) - 17'(rate_a);
    rate_big = (rate_a > 14'(RATE_LIM)) || (rate_a < -14'(RATE_LIM));
    if (rate_big) begin
      ri_nxt = 15'd0;
    end else if (ri_sum > 17'(RI_LIM)) begin
      ri_nxt = 15'(RI_LIM);
    end else if (ri_sum < -17'(RI_LIM)) begin
      ri_nxt = -15'(RI_LIM);
    end else begin
      ri_nxt = 15'(ri_sum);
    end

    if (rc_a > 11'(CMD_LIM)) begin
      rc_cl = 11'(CMD_LIM);
    end else if (rc_a < -11'(CMD_LIM)) begin
      rc_cl = -11'(CMD_LIM);
    end else begin
      rc_cl = rc_a;
    end
    err_nxt = 13'(rc_cl) - 13'(ang_a);

    li_sum = 16'(li_r[axis_r]) + 16'(err_r);
    if (li_sum > 16'(LI_LIM)) begin
      li_nxt = 15'(LI_LIM);
    end else if (li_sum < -16'(LI_LIM)) begin
      li_nxt = -15'(LI_LIM);
    end else begin
      li_nxt = 15'(li_sum);
    end

    pacc_sh = 20'(prod >>> 7);
    if (pacc_sh > 20'(CMD_LIM)) begin
      pacc_nxt = 10'(CMD_LIM);
    end else if (pacc_sh < -20'(CMD_LIM)) begin
      pacc_nxt = -10'(CMD_LIM);
    end else begin
      pacc_nxt = 10'(pacc_sh);
    end

    delta = 15'(rate_a) - 15'(prev_r[axis_r]);

    drv_sum = 20'(p_r) + 20'(i_r) - 20'(d_r);
    if (drv_sum > 20'(DRIVE_MAX)) begin
      drv_sat = 16'(DRIVE_MAX);
    end else if (drv_sum < 20'(DRIVE_MIN)) begin
      drv_sat = 16'(DRIVE_MIN);
    end else begin
      drv_sat = 16'(drv_sum);
    end
  end

  // operand selection for the product issued in each step
  always_comb begin
    mreq.en = (state_r == ST_RUN) && (step_r <= S_IBLEND);
    mreq.a  = '0;
    mreq.b  = '0;
    case (step_r)
      S_UPD: begin
        mreq.a = AW'(rc_a);
        mreq.b = BW'(pg_a);
      end
      S_PRATE: begin
        mreq.a = AW'(ri_r[axis_r] >>> 7);
        mreq.b = BW'(ig_a);
      end
      S_IRATE: begin
        mreq.a = AW'(err_r);
        mreq.b = BW'(lp_gain_r);
      end
      S_PACC: begin
        mreq.a = AW'(li_r[axis_r]);
        mreq.b = BW'(li_gain_r);
      end
      S_IACC: begin
        mreq.a = AW'(p_r) - AW'(pacc_r);
        mreq.b = BW'(prop_r);
      end
      S_PBLEND: begin
        mreq.a = AW'(i_r) - AW'(iacc_r);
        mreq.b = BW'(prop_r);
      end
      S_IBLEND: begin
        mreq.a = AW'(rate_a);
        mreq.b = BW'(damp_a);
      end
      default: ;
    endcase
  end

  // integrators and gyro history
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 2; k++) begin
        ri_r[k]   <= '0;
        li_r[k]   <= '0;
        prev_r[k] <= '0;
        dold_r[k] <= '0;
        dnew_r[k] <= '0;
      end
    end else if (in_xfer) begin
      if (in_if.reset_integrators) begin
        for (int k = 0; k < 2; k++) begin
          ri_r[k] <= '0;
          li_r[k] <= '0;
        end
      end
    end else if (state_r == ST_RUN) begin
      if (step_r == S_UPD) begin
        ri_r[axis_r] <= ri_nxt;
      end
      if (step_r == S_PRATE && levelled) begin
        li_r[axis_r] <= li_nxt;
      end
      if (step_r == S_DAMP) begin
        prev_r[axis_r] <= rate_a;
        dold_r[axis_r] <= dnew_r[axis_r];
        dnew_r[axis_r] <= delta;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (state_r == ST_RUN) begin
      case (step_r)
        S_UPD:    err_r  <= err_nxt;
        S_PRATE:  p_r    <= 18'(prod >>> 6);
        S_IRATE:  i_r    <= 12'(prod >>> 6);
        S_PACC:   pacc_r <= pacc_nxt;
        S_IACC:   iacc_r <= 12'(prod >>> 12);
        S_PBLEND: begin
          if (levelled) begin
            p_r <= 18'(pacc_r) + 18'(prod >>> 9);
          end
        end
        S_IBLEND: begin
          if (levelled) begin
            i_r <= iacc_r + 12'(prod >>> 9);
          end
        end
        S_DAMP: begin
          p_r <= p_r - 18'(prod >>> 6);
          d_r <= 17'(dnew_r[axis_r]) + 17'(dold_r[axis_r]) + 17'(delta);
        end
        S_DRIVE: begin
          if (!axis_r) begin
            drv0_r <= drv_sat;
          end
        end
        default: ;
      endcase
    end
    if (finish) begin
      roll_out_r  <= drv0_r;
      pitch_out_r <= drv_sat;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.roll_drive  = roll_out_r;
  assign out_if.pitch_drive = pitch_out_r;

  // ---------------------------------------------------------------- checks
`ifndef ASSERT_OFF
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r == ST_RUN) && (step_r == S_UPD) && !axis_r)
    else $error("sequencer did not start on roll after input transfer");

  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |->
      $past((state_r == ST_RUN) && (step_r == S_DRIVE) && axis_r))
    else $error("result raised outside the final pitch step");

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= S_DRIVE)
    else $error("step counter out of range");

  a_ri_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (ri_r[0] <= 15'(RI_LIM)) && (ri_r[0] >= -15'(RI_LIM)) &&
    (ri_r[1] <= 15'(RI_LIM)) && (ri_r[1] >= -15'(RI_LIM)))
    else $error("rate integrator outside clamp");

  a_li_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (li_r[0] <= 15'(LI_LIM)) && (li_r[0] >= -15'(LI_LIM)) &&
    (li_r[1] <= 15'(LI_LIM)) && (li_r[1] >= -15'(LI_LIM)))
    else $error("level integrator outside clamp");
`endif

endmodule

/* dv/rpap_tb_pkg.sv */
`timescale 1ns / 1ps
// rpap_tb_pkg: register indexes, level modes and item types shared by the
// attitude PID testbench and its checker. Depends on rpap_pkg for widths.

package rpap_tb_pkg;
  import rpap_pkg::*;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROLL_P     = 3'd0,
    REG_ROLL_I     = 3'd1,
    REG_PITCH_P    = 3'd2,
    REG_PITCH_I    = 3'd3,
    REG_LEVEL_P    = 3'd4,
    REG_LEVEL_I    = 3'd5,
    REG_LEVEL_MODE = 3'd6
  } gain_reg_e;

  typedef enum logic [1:0] {
    MODE_ACRO    = 2'd0,
    MODE_ANGLE   = 2'd1,
    MODE_HORIZON = 2'd2,
    MODE_UNUSED  = 2'd3
  } level_mode_e;

  typedef struct packed {
    logic signed [CMD_W-1:0]  roll_command;
    logic signed [CMD_W-1:0]  pitch_command;
    logic signed [RATE_W-1:0] roll_rate;
    logic signed [RATE_W-1:0] pitch_rate;
    logic signed [ANG_W-1:0]  roll_angle;
    logic signed [ANG_W-1:0]  pitch_angle;
    logic [GAIN_W-1:0]        roll_rate_damp_gain;
    logic [GAIN_W-1:0]        pitch_rate_damp_gain;
    logic                     reset_integrators;
  } attitude_item_t;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] roll_drive;
    logic signed [DRIVE_W-1:0] pitch_drive;
  } drive_pair_t;

  typedef struct packed {
    logic [GAIN_W-1:0] roll_p;
    logic [GAIN_W-1:0] roll_i;
    logic [GAIN_W-1:0] pitch_p;
    logic [GAIN_W-1:0] pitch_i;
    logic [GAIN_W-1:0] level_p;
    logic [GAIN_W-1:0] level_i;
    level_mode_e       mode;
  } gain_set_t;

endpackage

/* dv/rpap_attitude_checker.sv */
`timescale 1ns / 1ps
// rpap_attitude_checker: watches both channels and the register port, predicts
// the roll/pitch drives and compares. Depends on rpap_pkg, rpap_tb_pkg, rpap_if.

module rpap_attitude_checker
  import rpap_pkg::*, rpap_tb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  rpap_in_if                    in_mon,
  rpap_out_if                   out_mon,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    errors,
  output int                    awaited
);

  localparam gain_set_t RESET_GAINS = '{
    roll_p: 8'd40, roll_i: 8'd30, pitch_p: 8'd40, pitch_i: 8'd30,
    level_p: 8'd90, level_i: 8'd10, mode: MODE_HORIZON
  };

  gain_set_t                gains;
  logic signed [14:0]       rate_acc   [2];
  logic signed [14:0]       level_acc  [2];
  logic signed [RATE_W-1:0] last_rate  [2];
  logic signed [14:0]       delta_prev [2];
  logic signed [14:0]       delta_last [2];
  drive_pair_t              expected_drives [$];
  int                       mismatch_tally = 0;

  function automatic longint clamp(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // One control step of both axes; updates the predicted state.
  function automatic drive_pair_t predict_drives(attitude_item_t it);
    longint cmd [2], rate [2], ang [2], damp [2], pg [2], ig [2];
    longint blend, rc, p, i, d, delta, err, p_lvl, i_lvl, acc, lp, li;
    logic signed [DRIVE_W-1:0] drive [2];
    bit levelled;
    cmd[0]  = it.roll_command;         cmd[1]  = it.pitch_command;
    rate[0] = it.roll_rate;            rate[1] = it.pitch_rate;
    ang[0]  = it.roll_angle;           ang[1]  = it.pitch_angle;
    damp[0] = it.roll_rate_damp_gain;  damp[1] = it.pitch_rate_damp_gain;
    pg[0]   = gains.roll_p;            pg[1]   = gains.pitch_p;
    ig[0]   = gains.roll_i;            ig[1]   = gains.pitch_i;
    lp      = gains.level_p;
    li      = gains.level_i;
    levelled = (gains.mode == MODE_ANGLE) || (gains.mode == MODE_HORIZON);

    if (it.reset_integrators) begin
      for (int a = 0; a < 2; a++) begin
        rate_acc[a]  = '0;
        level_acc[a] = '0;
      end
    end

    // horizon blend: larger stick magnitude, capped at 512
    blend = 0;
    if (gains.mode == MODE_HORIZON) begin
      blend = (cmd[0] < 0) ? -cmd[0] : cmd[0];
      if (((cmd[1] < 0) ? -cmd[1] : cmd[1]) > blend)
        blend = (cmd[1] < 0) ? -cmd[1] : cmd[1];
      if (blend > 512)
        blend = 512;
    end

    for (int a = 0; a < 2; a++) begin
      rc  = cmd[a] * 2;
      acc = clamp(rate_acc[a] + rc - rate[a], -16000, 16000);
      if (rate[a] > 640 || rate[a] < -640)
        acc = 0;
      rate_acc[a] = acc[14:0];
      i = ((acc >>> 7) * ig[a]) >>> 6;
      p = (rc * pg[a]) >>> 6;

      if (levelled) begin
        err   = clamp(rc, -500, 500) - ang[a];
        acc   = clamp(level_acc[a] + err, -10000, 10000);
        level_acc[a] = acc[14:0];
        p_lvl = clamp((err * lp) >>> 7, -500, 500);
        i_lvl = (acc * li) >>> 12;
        i = i_lvl + (((i - i_lvl) * blend) >>> 9);
        p = p_lvl + (((p - p_lvl) * blend) >>> 9);
      end
      p = p - ((rate[a] * damp[a]) >>> 6);

      // three-tap D sum over gyro deltas
      delta = rate[a] - last_rate[a];
      last_rate[a] = rate[a][RATE_W-1:0];
      d = delta_last[a] + delta_prev[a] + delta;
      delta_prev[a] = delta_last[a];
      delta_last[a] = delta[14:0];

      drive[a] = DRIVE_W'(clamp(p + i - d, -32768, 32767));
    end
    return '{roll_drive: drive[0], pitch_drive: drive[1]};
  endfunction

  always @(posedge clk) begin
    drive_pair_t want;
    if (!rst_n) begin
      gains = RESET_GAINS;
      for (int a = 0; a < 2; a++) begin
        rate_acc[a]   = '0;
        level_acc[a]  = '0;
        last_rate[a]  = '0;
        delta_prev[a] = '0;
        delta_last[a] = '0;
      end
      expected_drives.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_drives.size() == 0) begin
          $error("result with nothing expected: roll_drive %0d, pitch_drive %0d",
                 out_mon.roll_drive, out_mon.pitch_drive);
          mismatch_tally++;
        end else begin
          want = expected_drives.pop_front();
          if (out_mon.roll_drive !== want.roll_drive) begin
            $error("roll_drive: expected %0d, actual %0d", want.roll_drive,
                   out_mon.roll_drive);
            mismatch_tally++;
          end
          if (out_mon.pitch_drive !== want.pitch_drive) begin
            $error("pitch_drive: expected %0d, actual %0d", want.pitch_drive,
                   out_mon.pitch_drive);
            mismatch_tally++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        expected_drives.push_back(predict_drives('{
          in_mon.roll_command, in_mon.pitch_command, in_mon.roll_rate,
          in_mon.pitch_rate, in_mon.roll_angle, in_mon.pitch_angle,
          in_mon.roll_rate_damp_gain, in_mon.pitch_rate_damp_gain,
          in_mon.reset_integrators}));
      if (cfg_we) begin
        case (cfg_index)
          REG_ROLL_P:     gains.roll_p  = cfg_data;
          REG_ROLL_I:     gains.roll_i  = cfg_data;
          REG_PITCH_P:    gains.pitch_p = cfg_data;
          REG_PITCH_I:    gains.pitch_i = cfg_data;
          REG_LEVEL_P:    gains.level_p = cfg_data;
          REG_LEVEL_I:    gains.level_i = cfg_data;
          REG_LEVEL_MODE: gains.mode    = level_mode_e'(cfg_data[1:0]);
          default: ;
        endcase
      end
    end
    errors  <= mismatch_tally;
    awaited <= expected_drives.size();
  end

endmodule

/* dv/tb_roll_pitch_attitude_pid.sv */
`timescale 1ns / 1ps
// tb_roll_pitch_attitude_pid: stimulus and verdict for the roll/pitch attitude
// PID. Depends on rpap_pkg, rpap_tb_pkg, rpap_if and rpap_attitude_checker.

module tb_roll_pitch_attitude_pid;
  import rpap_pkg::*;
  import rpap_tb_pkg::*;

  localparam int ITEMS_PER_SETTING = 256;
  localparam int SETTING_COUNT     = 6;
  // no transfer on either channel for this long means the block has hung;
  // worst honest case is the long receiver hold-off plus the processing of one item
  localparam int STALL_LIMIT       = 5000;
  localparam int HOLD_OFF_CYCLES   = 400;
  localparam int HOLD_AT_ITEM      = 60;
  // allow a margin for stray late results
  localparam int DRAIN_CYCLES      = 40;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int   send_idle_pct;
  int   recv_idle_pct;
  logic hold_go;
  bit   hold_done;
  int   hold_left;
  int   quiet_cycles;
  int   mismatches;
  int   awaited;

  // state of the current well-formed run: sticks and attitude held roughly
  // steady so that both integrators wind up to their clamps
  int run_left;
  int run_cmd [2];
  int run_ang [2];

  rpap_in_if  in_ch ();
  rpap_out_if out_ch ();

  roll_pitch_attitude_pid DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  rpap_attitude_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_mon    (in_ch),
    .out_mon   (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (mismatches),
    .awaited   (awaited)
  );

  always #5 clk = ~clk;

  // Result side: random back-pressure, plus one long hold-off on request so
  // the block fills up and has to refuse input transfers.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_go && !hold_done) begin
      hold_done    <= 1'b1;
      hold_left    <= HOLD_OFF_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: counts cycles without any transfer on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic int clip(int v, int lo, int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic attitude_item_t make_item(int cmd_r, int cmd_p, int rate_r,
                                               int rate_p, int ang_r, int ang_p,
                                               int damp_r, int damp_p, bit clr);
    attitude_item_t it;
    it.roll_command         = CMD_W'(cmd_r);
    it.pitch_command        = CMD_W'(cmd_p);
    it.roll_rate            = RATE_W'(rate_r);
    it.pitch_rate           = RATE_W'(rate_p);
    it.roll_angle           = ANG_W'(ang_r);
    it.pitch_angle          = ANG_W'(ang_p);
    it.roll_rate_damp_gain  = GAIN_W'(damp_r);
    it.pitch_rate_damp_gain = GAIN_W'(damp_p);
    it.reset_integrators    = clr;
    return it;
  endfunction

  // Mostly runs of near-steady sticks and small gyro rates; some pure noise
  // over every bit of every field, and the odd full-scale gyro kick.
  function automatic attitude_item_t next_random_item();
    logic [95:0] noise;
    int          pick;
    int          rate_span;
    attitude_item_t it;
    if (run_left == 0) begin
      run_left   = $urandom_range(40, 6);
      run_cmd[0] = int'($urandom_range(1000)) - 500;
      run_cmd[1] = int'($urandom_range(1000)) - 500;
      run_ang[0] = int'($urandom_range(3600)) - 1800;
      run_ang[1] = int'($urandom_range(3600)) - 1800;
    end
    run_left--;
    pick = $urandom_range(99);
    if (pick < 12) begin
      noise = {$urandom, $urandom, $urandom};
      it    = noise[$bits(attitude_item_t)-1:0];
    end else begin
      rate_span = (pick < 22) ? 8192 : 700;
      it = make_item(clip(run_cmd[0] + int'($urandom_range(40)) - 20, -512, 511),
                     clip(run_cmd[1] + int'($urandom_range(40)) - 20, -512, 511),
                     clip(int'($urandom_range(2 * rate_span)) - rate_span, -8192, 8191),
                     clip(int'($urandom_range(2 * rate_span)) - rate_span, -8192, 8191),
                     clip(run_ang[0] + int'($urandom_range(100)) - 50, -2048, 2047),
                     clip(run_ang[1] + int'($urandom_range(100)) - 50, -2048, 2047),
                     $urandom_range(255), $urandom_range(255),
                     pick >= 97);
    end
    return it;
  endfunction

  // Offer one item and hold it until the transfer; valid stays high when
  // the next item follows without a gap.
  task automatic send_item(input attitude_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid                <= 1'b1;
    in_ch.roll_command         <= it.roll_command;
    in_ch.pitch_command        <= it.pitch_command;
    in_ch.roll_rate            <= it.roll_rate;
    in_ch.pitch_rate           <= it.pitch_rate;
    in_ch.roll_angle           <= it.roll_angle;
    in_ch.pitch_angle          <= it.pitch_angle;
    in_ch.roll_rate_damp_gain  <= it.roll_rate_damp_gain;
    in_ch.pitch_rate_damp_gain <= it.pitch_rate_damp_gain;
    in_ch.reset_integrators    <= it.reset_integrators;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Stop offering and wait for every predicted drive pair to come back.
  // The checker's count is registered, hence the first wait.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (awaited != 0)
      @(posedge clk);
  endtask

  // Caller lowers cfg_we once the last write is out.
  task automatic write_reg(input gain_reg_e idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  task automatic load_gains(input gain_set_t g);
    write_reg(REG_ROLL_P,     g.roll_p);
    write_reg(REG_ROLL_I,     g.roll_i);
    write_reg(REG_PITCH_P,    g.pitch_p);
    write_reg(REG_PITCH_I,    g.pitch_i);
    write_reg(REG_LEVEL_P,    g.level_p);
    write_reg(REG_LEVEL_I,    g.level_i);
    write_reg(REG_LEVEL_MODE, CFG_DATA_W'(g.mode));
    cfg_we <= 1'b0;
  endtask

  initial begin
    attitude_item_t directed [$];
    gain_set_t      plan [SETTING_COUNT];

    rst_n                      = 1'b0;
    cfg_we                     = 1'b0;
    cfg_index                  = '0;
    cfg_data                   = '0;
    in_ch.valid                = 1'b0;
    in_ch.roll_command         = '0;
    in_ch.pitch_command        = '0;
    in_ch.roll_rate            = '0;
    in_ch.pitch_rate           = '0;
    in_ch.roll_angle           = '0;
    in_ch.pitch_angle          = '0;
    in_ch.roll_rate_damp_gain  = '0;
    in_ch.pitch_rate_damp_gain = '0;
    in_ch.reset_integrators    = 1'b0;
    hold_go                    = 1'b0;
    run_left                   = 0;
    send_idle_pct              = 28;
    recv_idle_pct              = 49;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, reset gains (horizon blend):
    // zero item, stick extremes incl. full blend at -512, gyro either side of
    // the 640 integrator cut-off, full-scale gyro with max damping, then a
    // full-scale reversal to saturate the drive, angle extremes, a wind-up
    // run and an integrator clear.
    directed.push_back(make_item(   0,    0,     0,     0,     0,     0,   0,   0, 0));
    directed.push_back(make_item( 511, -512,     0,     0,     0,     0,   0,   0, 0));
    directed.push_back(make_item( 500, -500,   640,  -640,     0,     0,  64,  64, 0));
    directed.push_back(make_item(-500,  500,   641,  -641,     0,     0,  64,  64, 0));
    directed.push_back(make_item(   0,    0,  8191, -8192,     0,     0, 255, 255, 0));
    directed.push_back(make_item(   0,    0, -8192,  8191,  2047, -2048, 255, 255, 0));
    directed.push_back(make_item(-500,  500,     0,     0, -1800,  1800,   0,   0, 0));
    directed.push_back(make_item(   0,    0,     0,     0,  1800, -1800,   0,   0, 0));
    for (int n = 0; n < 8; n++)
      directed.push_back(make_item(511, -512, -100, 100, -1800, 1800, 10, 10, 0));
    directed.push_back(make_item( 511, -512, -100,   100, -1800,  1800,  10,  10, 1));
    directed.push_back(make_item(-512,  511,   -1,    -1, -2048,  2047, 128,   1, 0));
    foreach (directed[n])
      send_item(directed[n]);
    drain_results();

    // Settings: all-max acro, all-zero angle, random horizon, the meaningless
    // mode three (acts as acro), strong self-level, random horizon.
    plan[0] = '{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, MODE_ACRO};
    plan[1] = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, MODE_ANGLE};
    for (int s = 2; s < SETTING_COUNT; s++)
      plan[s] = '{GAIN_W'($urandom_range(255)), GAIN_W'($urandom_range(255)),
                  GAIN_W'($urandom_range(255)), GAIN_W'($urandom_range(255)),
                  GAIN_W'($urandom_range(255)), GAIN_W'($urandom_range(255)),
                  MODE_HORIZON};
    plan[3].mode    = MODE_UNUSED;
    plan[4].mode    = MODE_ANGLE;
    plan[4].level_p = 8'd255;
    plan[4].level_i = 8'd255;

    for (int s = 0; s < SETTING_COUNT; s++) begin
      load_gains(plan[s]);
      // idling: sender-light first, receiver-light next, then none at all
      if (s < 2) begin
        send_idle_pct <= 28;
        recv_idle_pct <= 49;
      end else if (s < 4) begin
        send_idle_pct <= 49;
        recv_idle_pct <= 28;
      end else begin
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
      end
      for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
        if (s == SETTING_COUNT - 1 && n == HOLD_AT_ITEM)
          hold_go <= 1'b1;
        send_item(next_random_item());
      end
      drain_results();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
